// File: rtl/bfpu_pkg.sv
// shared constants and control types for the bit-field pack/unpack engine
package bfpu_pkg;

	localparam int unsigned BUFFER_BYTES = 4096;
	localparam int unsigned BUF_BITS     = BUFFER_BYTES * 8;
	localparam int unsigned ROW_BITS     = 64;
	localparam int unsigned ROW_BYTES    = ROW_BITS / 8;
	localparam int unsigned ROWS         = (BUFFER_BYTES + ROW_BYTES - 1) / ROW_BYTES;
	localparam int unsigned ROW_AW       = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int unsigned WIN_BITS     = 2 * ROW_BITS;
	localparam int unsigned MAX_COUNT    = 64;

	localparam int unsigned START_W = 15;
	localparam int unsigned COUNT_W = 7;
	localparam int unsigned VALUE_W = 64;
	localparam int unsigned OFF_W   = $clog2(ROW_BITS);
	localparam int unsigned SH_W    = $clog2(WIN_BITS);

	typedef enum logic {
		FUNC_WRITE = 1'b0,
		FUNC_READ  = 1'b1
	} bfpu_func_t;

	typedef struct packed {
		logic              load;
		logic              rd0;
		logic              rd1;
		logic              ex;
		logic              wr1;
		logic              clr;
		logic [ROW_AW-1:0] clr_addr;
		logic              out_load;
	} bfpu_cmd_t;

	typedef struct packed {
		logic err;
		logic is_read;
		logic spill;
	} bfpu_sts_t;

endpackage

// File: rtl/bfpu_req_if.sv
// request channel: valid/ready with the field request payload
interface bfpu_req_if;
	import bfpu_pkg::*;

	logic               valid;
	logic               ready;
	logic               func;
	logic [START_W-1:0] bit_start;
	logic [COUNT_W-1:0] bit_count;
	logic [VALUE_W-1:0] write_value;

	modport source (output valid, func, bit_start, bit_count, write_value, input ready);
	modport sink (input valid, func, bit_start, bit_count, write_value, output ready);
endinterface

// File: rtl/bfpu_rsp_if.sv
// response channel: valid/ready with the read value and error flag
interface bfpu_rsp_if;
	import bfpu_pkg::*;

	logic               valid;
	logic               ready;
	logic [VALUE_W-1:0] read_value;
	logic               range_error;

	modport source (output valid, read_value, range_error, input ready);
	modport sink (input valid, read_value, range_error, output ready);
endinterface

// File: rtl/bfpu_ctrl.sv
// sequencer: clearing pass, read-modify-write steps and output handshake
module bfpu_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	output logic                rsp_valid,
	input  logic                rsp_ready,
	input  bfpu_pkg::bfpu_sts_t sts,
	output bfpu_pkg::bfpu_cmd_t cmd
);
	import bfpu_pkg::*;

	typedef enum logic [2:0] {
		S_CLR,
		S_IDLE,
		S_RD0,
		S_RD1,
		S_EX,
		S_WR1,
		S_DONE
	} state_t;

	state_t            state_q;
	logic [ROW_AW-1:0] clr_cnt_q;
	logic              out_valid_q;
	logic              out_free;

	assign out_free  = !out_valid_q || rsp_ready;
	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = out_valid_q;

	always_comb begin
		cmd          = '0;
		cmd.load     = (state_q == S_IDLE) && req_valid;
		cmd.rd0      = (state_q == S_RD0);
		cmd.rd1      = (state_q == S_RD1);
		cmd.ex       = (state_q == S_EX);
		cmd.wr1      = (state_q == S_WR1);
		cmd.clr      = (state_q == S_CLR);
		cmd.clr_addr = clr_cnt_q;
		cmd.out_load = (state_q == S_DONE) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			clr_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLR: begin
					clr_cnt_q <= clr_cnt_q + 1'b1;
					if (clr_cnt_q == ROW_AW'(ROWS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (req_valid) begin
						state_q <= S_RD0;
					end
				end
				S_RD0: begin
					state_q <= sts.err ? S_DONE : S_RD1;
				end
				S_RD1: begin
					state_q <= S_EX;
				end
				S_EX: begin
					// second row only needs writing when the field crosses into it
					state_q <= (!sts.is_read && sts.spill) ? S_WR1 : S_DONE;
				end
				S_WR1: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end
endmodule

// File: rtl/bfpu_datapath.sv
// row buffer, field window alignment, merge and result registers
module bfpu_datapath (
	input  logic                         clk,
	input  bfpu_pkg::bfpu_cmd_t          cmd,
	output bfpu_pkg::bfpu_sts_t          sts,
	input  logic                         func,
	input  logic [bfpu_pkg::START_W-1:0] bit_start,
	input  logic [bfpu_pkg::COUNT_W-1:0] bit_count,
	input  logic [bfpu_pkg::VALUE_W-1:0] write_value,
	output logic [bfpu_pkg::VALUE_W-1:0] read_value,
	output logic                         range_error
);
	import bfpu_pkg::*;

	// row r holds bytes 8r..8r+7, byte 0 in the top bits, so position order is msb first
	logic [ROW_BITS-1:0] mem_q [ROWS];
	logic [ROW_BITS-1:0] rd_q;

	logic               func_q;
	logic [START_W-1:0] start_q;
	logic [COUNT_W-1:0] count_q;
	logic [VALUE_W-1:0] wval_q;

	logic [SH_W-1:0]     sh_q;
	logic                err_q;
	logic [ROW_BITS-1:0] hi_q;
	logic [ROW_BITS-1:0] lo_q;
	logic [WIN_BITS-1:0] mask_q;
	logic [WIN_BITS-1:0] data_q;
	logic [VALUE_W-1:0]  res_q;
	logic [VALUE_W-1:0]  read_value_q;
	logic                range_error_q;

	logic [OFF_W-1:0]    off;
	logic [ROW_AW-1:0]   row0;
	logic [ROW_AW-1:0]   row1;
	logic [15:0]         end_pos;
	logic [VALUE_W-1:0]  fmask;
	logic [WIN_BITS-1:0] win;
	logic [WIN_BITS-1:0] new_win;
	logic [WIN_BITS-1:0] rd_win;
	logic                we;
	logic [ROW_AW-1:0]   waddr;
	logic [ROW_BITS-1:0] wdata;
	logic [ROW_AW-1:0]   raddr;

	assign off     = start_q[OFF_W-1:0];
	assign row0    = ROW_AW'(start_q >> OFF_W);
	assign row1    = row0 + 1'b1;
	assign end_pos = 16'(start_q) + 16'(count_q);
	assign fmask   = {VALUE_W{1'b1}} >> (COUNT_W'(MAX_COUNT) - count_q);

	assign sts.err = (count_q == '0) || (count_q > COUNT_W'(MAX_COUNT))
		|| (32'(end_pos) > BUF_BITS);
	assign sts.is_read = (func_q == FUNC_READ);
	assign sts.spill   = ((COUNT_W'(off) + count_q) > COUNT_W'(ROW_BITS));

	assign win     = {hi_q, rd_q};
	assign new_win = (win & ~mask_q) | data_q;
	assign rd_win  = (win & mask_q) >> sh_q;

	always_comb begin
		we    = cmd.clr || (cmd.ex && (func_q == FUNC_WRITE)) || cmd.wr1;
		waddr = row1;
		wdata = lo_q;
		if (cmd.clr) begin
			waddr = cmd.clr_addr;
			wdata = '0;
		end else if (cmd.ex) begin
			waddr = row0;
			wdata = new_win[WIN_BITS-1:ROW_BITS];
		end
		raddr = cmd.rd0 ? row0 : row1;
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rd_q <= mem_q[raddr];
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q  <= func;
			start_q <= bit_start;
			count_q <= bit_count;
			wval_q  <= write_value;
		end
		if (cmd.rd0) begin
			err_q <= sts.err;
			sh_q  <= SH_W'(8'(WIN_BITS) - 8'(off) - 8'(count_q));
		end
		if (cmd.rd1) begin
			hi_q   <= rd_q;
			mask_q <= {{ROW_BITS{1'b0}}, fmask} << sh_q;
			data_q <= {{ROW_BITS{1'b0}}, wval_q & fmask} << sh_q;
		end
		if (cmd.ex) begin
			lo_q  <= new_win[ROW_BITS-1:0];
			res_q <= sts.is_read ? rd_win[VALUE_W-1:0] : '0;
		end
		if (cmd.out_load) begin
			read_value_q  <= err_q ? '0 : res_q;
			range_error_q <= err_q;
		end
	end

	assign read_value  = read_value_q;
	assign range_error = range_error_q;
endmodule

// File: rtl/bit_field_pack_unpack_engine_top.sv
// top level of the bit-field pack/unpack engine
// after reset a clearing pass zeroes the buffer's 512 rows, one 64-bit row per cycle,
// during which no item is accepted
// a read or a write within one row steps through RD0, RD1 and EX, then loads its result
// in DONE; a write crossing into the next row adds WR1, a rejected item goes from RD0
// straight to DONE; the row memory (two row reads, then up to two row writes) sets these steps
// one item at a time, a new one accepted only back in S_IDLE; the result register lets the
// next item in while a result waits
module bit_field_pack_unpack_engine_top (
	input  logic       clk,
	input  logic       arst_n,
	bfpu_req_if.sink   req,
	bfpu_rsp_if.source rsp
);
	import bfpu_pkg::*;

	bfpu_cmd_t cmd;
	bfpu_sts_t sts;

	bfpu_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	bfpu_datapath u_datapath (
		.clk         (clk),
		.cmd         (cmd),
		.sts         (sts),
		.func        (req.func),
		.bit_start   (req.bit_start),
		.bit_count   (req.bit_count),
		.write_value (req.write_value),
		.read_value  (rsp.read_value),
		.range_error (rsp.range_error)
	);

	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clr |-> !req.ready)
		else $error("item accepted during clearing pass");

	a_error_zero_value: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.range_error |-> rsp.read_value == '0)
		else $error("rejected item returned a nonzero value");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> !req.ready)
		else $error("second item accepted straight after the first");
endmodule
